>>> sv/ptc_pkg.sv
// Shared types and constants for the perceptron train and classify block.
`timescale 1ns / 1ps

package ptc_pkg;

	localparam int MAX_FEATURES = 64;
	localparam int FEAT_W       = 16;
	localparam int WEIGHT_W     = 32;
	localparam int FRAC_BITS    = 8;
	localparam int ACC_W        = 56;
	localparam int PROD_W       = FEAT_W + WEIGHT_W;
	localparam int SUM_W        = WEIGHT_W + 2;
	localparam int WADDR_W      = $clog2(MAX_FEATURES + 1);
	localparam int BADDR_W      = $clog2(MAX_FEATURES);
	localparam int CFG_W        = 7;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_W-1:0]          FC_RESET  = CFG_W'(4);
	localparam logic [WADDR_W-1:0]        BIAS_ADDR = WADDR_W'(MAX_FEATURES);
	// bias input is the constant -1 in Q.8
	localparam logic signed [FEAT_W-1:0]  BIAS_IN   = -(FEAT_W'(1) << FRAC_BITS);

	localparam logic OP_TRAIN = 1'b0;
	localparam logic OP_TEST  = 1'b1;

	typedef struct packed {
		logic                     opcode;
		logic signed [FEAT_W-1:0] feature_value;
		logic                     last_element;
		logic                     target_class;
		logic                     restart_set;
	} ptc_in_t;

	typedef struct packed {
		logic predicted_class;
		logic weights_changed;
		logic was_training;
	} ptc_out_t;

	// one element after front-end classification
	typedef struct packed {
		logic signed [FEAT_W-1:0] x;
		logic [BADDR_W-1:0]       idx;
		logic                     in_range;
		logic                     last;
		logic                     test;
		logic                     target;
		logic                     clear;
	} ptc_elem_t;

endpackage

>>> sv/ptc_front.sv
// Front end: accepts elements, tracks the element index and tags each element.
`timescale 1ns / 1ps

module ptc_front import ptc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                elem_valid,
	output logic                elem_ready,
	input  ptc_in_t             elem,
	input  logic [WADDR_W-1:0]  active_n,
	input  logic                q_full,
	output logic                push,
	output ptc_elem_t           entry
);

	logic [WADDR_W-1:0] fidx_q;

	assign elem_ready = !q_full;
	assign push       = elem_valid && elem_ready;

	always_comb begin
		entry.x        = elem.feature_value;
		entry.idx      = fidx_q[BADDR_W-1:0];
		entry.in_range = (fidx_q < active_n);
		entry.last     = elem.last_element;
		entry.test     = (elem.opcode == OP_TEST);
		entry.target   = elem.target_class;
		// restart only counts on a training element that opens its sample
		entry.clear    = elem.restart_set && (elem.opcode == OP_TRAIN) && (fidx_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fidx_q <= '0;
		end else if (push) begin
			if (elem.last_element) begin
				fidx_q <= '0;
			end else if (entry.in_range) begin
				fidx_q <= fidx_q + WADDR_W'(1);
			end
		end
	end

endmodule

>>> sv/ptc_queue.sv
// Short element queue between the front end and the engine.
`timescale 1ns / 1ps

module ptc_queue import ptc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ptc_elem_t din,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output ptc_elem_t head
);

	ptc_elem_t          ent_q [0:QUEUE_DEPTH-1];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QPTR_W:0]    cnt_q;

	assign full       = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sv/ptc_back.sv
// Engine: multiply-accumulate per element, bias, decision and weight update pass.
`timescale 1ns / 1ps

module ptc_back import ptc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  ptc_elem_t head,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_ready,
	output ptc_out_t  res
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MUL  = 8'b0000_0010,
		ST_ACC  = 8'b0000_0100,
		ST_BRD  = 8'b0000_1000,
		ST_DEC  = 8'b0001_0000,
		ST_URD  = 8'b0010_0000,
		ST_UWR  = 8'b0100_0000,
		ST_RES  = 8'b1000_0000
	} st_t;

	// storage
	logic signed [WEIGHT_W-1:0] wmem [0:MAX_FEATURES];
	logic signed [FEAT_W-1:0]   bmem [0:MAX_FEATURES-1];
	logic [MAX_FEATURES:0]      wvld_q;

	st_t                        st_q;
	ptc_elem_t                  cur_q;
	logic                       bias_q;
	logic                       ubias_q;
	logic                       pred_q;
	logic                       upd_q;
	logic [WADDR_W-1:0]         cnt_q;
	logic [WADDR_W-1:0]         i_q;
	logic [WADDR_W-1:0]         waddr_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [WEIGHT_W-1:0] wrd_q;
	logic                       wvld_rd_q;
	logic signed [FEAT_W-1:0]   brd_q;
	logic                       res_valid_q;
	ptc_out_t                   res_q;

	logic                       pop_ok;
	logic                       w_re;
	logic [WADDR_W-1:0]         w_raddr;
	logic [WADDR_W-1:0]         upd_addr;
	logic                       w_we;
	logic signed [WEIGHT_W-1:0] w_eff;
	logic signed [FEAT_W-1:0]   mul_x;
	logic signed [FEAT_W-1:0]   s_val;
	logic signed [SUM_W-1:0]    delta;
	logic signed [SUM_W-1:0]    usum;
	logic signed [WEIGHT_W-1:0] w_new;
	logic                       pred;
	logic                       res_load;

	assign pop_ok   = (st_q == ST_IDLE) || ((st_q == ST_ACC) && !bias_q && !cur_q.last);
	assign pop      = pop_ok && head_valid;
	assign upd_addr = (i_q == cnt_q) ? BIAS_ADDR : i_q;
	assign w_we     = (st_q == ST_UWR);
	assign w_eff    = wvld_rd_q ? wrd_q : '0;
	assign mul_x    = bias_q ? BIAS_IN : cur_q.x;
	assign pred     = !acc_q[ACC_W-1];
	assign res_load = (st_q == ST_RES) && (!res_valid_q || res_ready);

	always_comb begin
		w_re    = 1'b0;
		w_raddr = BIAS_ADDR;
		if (pop) begin
			w_re    = 1'b1;
			w_raddr = head.in_range ? WADDR_W'(head.idx) : BIAS_ADDR;
		end else if (st_q == ST_BRD) begin
			w_re    = 1'b1;
			w_raddr = BIAS_ADDR;
		end else if (st_q == ST_URD) begin
			w_re    = 1'b1;
			w_raddr = upd_addr;
		end
	end

	// update: w +/- sample, saturated to the weight width
	always_comb begin
		s_val = ubias_q ? BIAS_IN : brd_q;
		delta = pred_q ? -SUM_W'(s_val) : SUM_W'(s_val);
		usum  = SUM_W'(w_eff) + delta;
		if (usum[SUM_W-1:WEIGHT_W-1] == '0 || usum[SUM_W-1:WEIGHT_W-1] == '1) begin
			w_new = usum[WEIGHT_W-1:0];
		end else if (usum[SUM_W-1]) begin
			w_new = {1'b1, {(WEIGHT_W-1){1'b0}}};
		end else begin
			w_new = {1'b0, {(WEIGHT_W-1){1'b1}}};
		end
	end

	// memories and datapath registers
	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[waddr_q] <= w_new;
		end
		if (w_re) begin
			wrd_q <= wmem[w_raddr];
		end
		if (pop && head.in_range) begin
			bmem[head.idx] <= head.x;
		end
		if (st_q == ST_URD) begin
			brd_q   <= bmem[i_q[BADDR_W-1:0]];
			waddr_q <= upd_addr;
			ubias_q <= (i_q == cnt_q);
		end
		if (pop) begin
			cur_q <= head;
		end
		if (st_q == ST_MUL) begin
			prod_q <= mul_x * w_eff;
		end
		if (res_load) begin
			res_q.predicted_class <= pred_q;
			res_q.weights_changed <= upd_q;
			res_q.was_training    <= !cur_q.test;
		end
	end

	// weight valid bits: an entry not valid reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvld_q    <= '0;
			wvld_rd_q <= 1'b0;
		end else begin
			if (pop && head.clear) begin
				wvld_q <= '0;
			end else if (w_we) begin
				wvld_q[waddr_q] <= 1'b1;
			end
			if (w_re) begin
				wvld_rd_q <= wvld_q[w_raddr] && !(pop && head.clear);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			bias_q      <= 1'b0;
			pred_q      <= 1'b0;
			upd_q       <= 1'b0;
			cnt_q       <= '0;
			i_q         <= '0;
			acc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready && !res_load) begin
				res_valid_q <= 1'b0;
			end
			if (pop) begin
				bias_q <= !head.in_range;
				if (head.in_range) begin
					cnt_q <= WADDR_W'(head.idx) + WADDR_W'(1);
				end
			end
			case (st_q)
				ST_IDLE: begin
					if (pop && (head.in_range || head.last)) begin
						st_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					st_q <= ST_ACC;
				end
				ST_ACC: begin
					acc_q <= acc_q + ACC_W'(prod_q);
					if (bias_q) begin
						st_q <= ST_DEC;
					end else if (cur_q.last) begin
						st_q <= ST_BRD;
					end else if (pop && (head.in_range || head.last)) begin
						st_q <= ST_MUL;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_BRD: begin
					bias_q <= 1'b1;
					st_q   <= ST_MUL;
				end
				ST_DEC: begin
					pred_q <= pred;
					upd_q  <= !cur_q.test && (pred != cur_q.target);
					i_q    <= '0;
					st_q   <= (!cur_q.test && (pred != cur_q.target)) ? ST_URD : ST_RES;
				end
				ST_URD: begin
					st_q <= ST_UWR;
				end
				ST_UWR: begin
					if (ubias_q) begin
						st_q <= ST_RES;
					end else begin
						i_q  <= i_q + WADDR_W'(1);
						st_q <= ST_URD;
					end
				end
				ST_RES: begin
					if (res_load) begin
						res_valid_q <= 1'b1;
						acc_q       <= '0;
						cnt_q       <= '0;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> sv/perceptron_train_and_classify.sv
// Top level of the perceptron train and classify block.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+--------------------------------
//   elements  | elem_valid / elem_ready   | elem (ptc_in_t)
//   results   | res_valid / res_ready     | res (ptc_out_t)
//   config    | cfg_we (no wait)          | cfg_wdata = feature_count
//
// Steps: the engine picks up the first element of a sample. An in-range
// element takes a weight read and multiply, then an accumulate overlapped
// with the next element's read; elements past the feature count are taken in
// with no multiply. An in-range last element adds a bias read, multiply,
// accumulate, decision and result; a last element past the feature count adds
// a bias multiply, accumulate, decision and result. A misclassified training
// sample adds a read-modify-write pass over the weight RAM that reads and then
// writes each weight in turn, one per feature taken and one for the bias.
// Reset clears all weights at once through per-entry valid bits; no sweep.
// The front end keeps taking elements into a 4-entry queue while the engine
// works or waits on a stalled result; results wait in one output register.
`timescale 1ns / 1ps

module perceptron_train_and_classify import ptc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             elem_valid,
	output logic             elem_ready,
	input  ptc_in_t          elem,
	output logic             res_valid,
	input  logic             res_ready,
	output ptc_out_t         res,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic [CFG_W-1:0]   fc_q;
	logic [WADDR_W-1:0] active_n;
	logic               q_full;
	logic               push;
	ptc_elem_t          entry;
	logic               pop;
	logic               head_valid;
	ptc_elem_t          head;

	// feature_count register; the user must write it only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= FC_RESET;
		end else if (cfg_we) begin
			fc_q <= cfg_wdata;
		end
	end

	// counts above the weight store size act as the maximum
	assign active_n = (fc_q > CFG_W'(MAX_FEATURES)) ? WADDR_W'(MAX_FEATURES) : WADDR_W'(fc_q);

	ptc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem_valid (elem_valid),
		.elem_ready (elem_ready),
		.elem       (elem),
		.active_n   (active_n),
		.q_full     (q_full),
		.push       (push),
		.entry      (entry)
	);

	ptc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.din        (entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ptc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

endmodule

>>> sv/ptc_checker.sv
// Port-level checks for the perceptron block, bound to the top level.
`timescale 1ns / 1ps

module ptc_assertions import ptc_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     elem_ready,
	input logic     res_valid,
	input logic     res_ready,
	input ptc_out_t res
);

	// a held result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res))
		else $error("result changed while stalled");

	// only training samples move the weights
	a_change_train: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!res.weights_changed || res.was_training))
		else $error("weight update reported for a test sample");

	// no result straight out of reset
	a_reset_res: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !res_valid)
		else $error("result offered right after reset");

	// empty queue after reset takes elements
	a_reset_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> elem_ready)
		else $error("not ready right after reset");

endmodule

bind perceptron_train_and_classify ptc_assertions u_ptc_assertions (.*);
